// ----- hw/rtl/tirb_pkg.sv -----
// Types and constants shared by the timer and interrupt register block.
package tirb_pkg;

  typedef enum logic [1:0] {
    KIND_TICK  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_WRITE = 2'd2
  } kind_t;

  localparam logic [31:0] ADDR_UART  = 32'hD000_0000;
  localparam logic [31:0] ADDR_FREE  = 32'hD100_0000;
  localparam logic [31:0] ADDR_MCNT  = 32'hD100_0004;
  localparam logic [31:0] ADDR_MVAL  = 32'hD100_0014;
  localparam logic [31:0] ADDR_CTRL  = 32'hD100_0020;
  localparam logic [31:0] ADDR_STAT  = 32'hD100_0024;
  localparam logic [31:0] ADDR_DEBUG = 32'hE000_0000;
  localparam logic [31:0] ADDR_STOP  = 32'hF000_0000;

  localparam int CTRL_MATCH_BIT = 1;
  localparam int IRQ_BIT        = 10;
  localparam int FIRQ_BIT       = 11;

  localparam logic [31:0] MATCH_VALUE_RESET = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] address;
    logic [31:0] write_data;
  } cmd_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        irq;
    logic        firq;
    logic        uart_valid;
    logic [7:0]  uart_byte;
    logic        debug_valid;
    logic [31:0] debug_value;
    logic        halt;
    logic        write_rejected;
  } rsp_item_t;

endpackage

// ----- hw/rtl/timer_irq_register_block.sv -----
// Timer, interrupt status and bus-mapped peripheral registers.
// The result of an accepted item appears in the output register in the following cycle.
// Throughput: one item per cycle; cmd_stall rises only while a held result is stalled.
// Reset (rst, synchronous, active high): both counters, control and status clear,
// match value goes to all ones, the output register empties.
module timer_irq_register_block
  import tirb_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      cmd_valid,
  output logic      cmd_stall,
  input  cmd_item_t cmd,
  output logic      rsp_valid,
  input  logic      rsp_stall,
  output rsp_item_t rsp
);

  logic [31:0] free_count, free_count_next;
  logic [31:0] match_count, match_count_next;
  logic [31:0] match_value, match_value_next;
  logic [31:0] control_word, control_word_next;
  logic [1:0]  status_bits, status_bits_next;
  rsp_item_t   result;
  logic        accept;

  assign cmd_stall = rsp_valid && rsp_stall;
  assign accept    = cmd_valid && !cmd_stall;

  always_comb begin
    free_count_next   = free_count;
    match_count_next  = match_count;
    match_value_next  = match_value;
    control_word_next = control_word;
    status_bits_next  = status_bits;
    result            = '0;
    case (cmd.kind)
      KIND_TICK: begin
        free_count_next = free_count + 32'd1;
        if (control_word[CTRL_MATCH_BIT] && (match_count >= match_value)) begin
          status_bits_next = 2'b11;
          match_count_next = '0;
        end else begin
          match_count_next = match_count + 32'd1;
        end
      end
      KIND_READ: begin
        case (cmd.address)
          ADDR_FREE: result.read_data = free_count;
          ADDR_MCNT: result.read_data = match_count;
          ADDR_MVAL: result.read_data = match_value;
          ADDR_CTRL: result.read_data = control_word;
          ADDR_STAT: result.read_data = {20'd0, status_bits, 10'd0};
          default:   result.read_data = '0;
        endcase
        result.halt = (cmd.address == ADDR_STOP);
      end
      KIND_WRITE: begin
        if (cmd.address == ADDR_UART) begin
          result.uart_valid = 1'b1;
          result.uart_byte  = cmd.write_data[7:0];
        end else if (cmd.address inside {ADDR_FREE, ADDR_MCNT}) begin
          result.write_rejected = 1'b1;
        end else if (cmd.address == ADDR_MVAL) begin
          match_value_next = cmd.write_data;
        end else if (cmd.address == ADDR_CTRL) begin
          control_word_next = cmd.write_data;
          if (cmd.write_data[CTRL_MATCH_BIT]) begin
            match_count_next = '0;
            status_bits_next = '0;
          end
        end else if (cmd.address == ADDR_STAT) begin
          status_bits_next = status_bits & ~cmd.write_data[FIRQ_BIT:IRQ_BIT];
        end else if (cmd.address == ADDR_DEBUG) begin
          result.debug_valid = 1'b1;
          result.debug_value = cmd.write_data;
        end else if (cmd.address == ADDR_STOP) begin
          result.halt = 1'b1;
        end
      end
      default: begin
      end
    endcase
    result.irq  = control_word_next[IRQ_BIT] && status_bits_next[0];
    result.firq = control_word_next[FIRQ_BIT] && status_bits_next[1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_count   <= '0;
      match_count  <= '0;
      match_value  <= MATCH_VALUE_RESET;
      control_word <= '0;
      status_bits  <= '0;
      rsp_valid    <= 1'b0;
    end else if (accept) begin
      free_count   <= free_count_next;
      match_count  <= match_count_next;
      match_value  <= match_value_next;
      control_word <= control_word_next;
      status_bits  <= status_bits_next;
      rsp_valid    <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rsp <= result;
    end
  end

endmodule

// ----- hw/rtl/tirb_checker.sv -----
// Port-level assertions for the timer register block and their bind.
module tirb_checker
  import tirb_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      cmd_valid,
  input logic      cmd_stall,
  input logic      rsp_valid,
  input logic      rsp_stall,
  input rsp_item_t rsp
);

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
    else $error("stalled result item changed or dropped");

  a_item_result: assert property (@(posedge clk) disable iff (rst)
    cmd_valid && !cmd_stall |=> rsp_valid)
    else $error("accepted item gave no result");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    cmd_stall |-> rsp_valid && rsp_stall)
    else $error("input stalled with no held result");

  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> $onehot0({rsp.uart_valid, rsp.debug_valid, rsp.halt,
                            rsp.write_rejected, rsp.read_data != 32'd0}))
    else $error("result flags not exclusive");

  a_payload_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.uart_valid || rsp.uart_byte == 8'd0) &&
                  (rsp.debug_valid || rsp.debug_value == 32'd0))
    else $error("payload set without its flag");

endmodule

bind timer_irq_register_block tirb_checker u_tirb_checker (.*);

// ----- dv/tb_timer_irq_register_block.sv -----
// Self-checking testbench for the timer and interrupt register block.
module tb_timer_irq_register_block;
  import tirb_pkg::*;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD = 250;
  localparam int RANDOM_PER_PHASE = 625;
  localparam int MAX_REPORTS = 50;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  cmd_item_t cmd = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_item_t rsp;

  cmd_item_t cmd_backlog[$];
  rsp_item_t due_rsp[$];

  logic [31:0] free_cnt = '0;
  logic [31:0] match_cnt = '0;
  logic [31:0] match_val = MATCH_VALUE_RESET;
  logic [31:0] ctrl_word = '0;
  logic [1:0] stat_bits = '0;

  logic [31:0] map_addr [8] = '{ADDR_UART, ADDR_FREE, ADDR_MCNT, ADDR_MVAL,
                                ADDR_CTRL, ADDR_STAT, ADDR_DEBUG, ADDR_STOP};

  int mismatches = 0;
  int gap_left = 0;
  int burst_left = 0;
  int hold_left = 0;
  int rsp_taken = 0;
  int rx_cycle = 0;
  int stall_mode = 0;
  int cycle_count = 0;

  timer_irq_register_block DUT (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd(cmd),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic rsp_item_t advance_timer_regs(cmd_item_t c);
    rsp_item_t r;
    r = '0;
    case (c.kind)
      KIND_TICK: begin
        free_cnt = free_cnt + 32'd1;
        if (ctrl_word[CTRL_MATCH_BIT] && match_cnt >= match_val) begin
          stat_bits = 2'b11;
          match_cnt = '0;
        end else begin
          match_cnt = match_cnt + 32'd1;
        end
      end
      KIND_READ: begin
        case (c.address)
          ADDR_FREE: r.read_data = free_cnt;
          ADDR_MCNT: r.read_data = match_cnt;
          ADDR_MVAL: r.read_data = match_val;
          ADDR_CTRL: r.read_data = ctrl_word;
          ADDR_STAT: r.read_data = 32'(stat_bits) << IRQ_BIT;
          ADDR_STOP: r.halt = 1'b1;
          default: ;
        endcase
      end
      KIND_WRITE: begin
        case (c.address)
          ADDR_UART: begin
            r.uart_valid = 1'b1;
            r.uart_byte = c.write_data[7:0];
          end
          ADDR_FREE, ADDR_MCNT: r.write_rejected = 1'b1;
          ADDR_MVAL: match_val = c.write_data;
          ADDR_CTRL: begin
            ctrl_word = c.write_data;
            if (c.write_data[CTRL_MATCH_BIT]) begin
              match_cnt = '0;
              stat_bits = '0;
            end
          end
          ADDR_STAT: stat_bits = stat_bits & ~{c.write_data[FIRQ_BIT], c.write_data[IRQ_BIT]};
          ADDR_DEBUG: begin
            r.debug_valid = 1'b1;
            r.debug_value = c.write_data;
          end
          ADDR_STOP: r.halt = 1'b1;
          default: ;
        endcase
      end
      default: ;
    endcase
    r.irq = ctrl_word[IRQ_BIT] & stat_bits[0];
    r.firq = ctrl_word[FIRQ_BIT] & stat_bits[1];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (mismatches < MAX_REPORTS)
      $display("ERROR %s: got %h, want %h (t=%0t)", what, got, want, $time);
    mismatches++;
  endtask

  task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  task automatic check_rsp(rsp_item_t got);
    rsp_item_t want;
    if (due_rsp.size() == 0) begin
      report_mismatch("item with none pending", got.read_data, '0);
    end else begin
      want = due_rsp.pop_front();
      check_field("read_data", got.read_data, want.read_data);
      check_field("irq", 32'(got.irq), 32'(want.irq));
      check_field("firq", 32'(got.firq), 32'(want.firq));
      check_field("uart_valid", 32'(got.uart_valid), 32'(want.uart_valid));
      check_field("uart_byte", 32'(got.uart_byte), 32'(want.uart_byte));
      check_field("debug_valid", 32'(got.debug_valid), 32'(want.debug_valid));
      check_field("debug_value", got.debug_value, want.debug_value);
      check_field("halt", 32'(got.halt), 32'(want.halt));
      check_field("write_rejected", 32'(got.write_rejected), 32'(want.write_rejected));
    end
  endtask

  task automatic push_cmd(logic [1:0] k, logic [31:0] a, logic [31:0] d);
    cmd_backlog.push_back('{k, a, d});
  endtask

  function automatic cmd_item_t random_cmd();
    cmd_item_t c;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 45) c.kind = KIND_TICK;
    else if (pick < 70) c.kind = KIND_READ;
    else if (pick < 97) c.kind = KIND_WRITE;
    else c.kind = KIND_UNUSED;
    pick = $urandom_range(0, 99);
    if (pick < 85) c.address = map_addr[$urandom_range(0, 7)];
    else if (pick < 93) c.address = map_addr[$urandom_range(0, 7)] ^ (32'd1 << $urandom_range(0, 31));
    else c.address = $urandom;
    c.write_data = $urandom;
    if (c.address == ADDR_MVAL) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) c.write_data = $urandom_range(0, 6);
      else if (pick == 7) c.write_data = '0;
      else if (pick == 8) c.write_data = '1;
    end else if (c.address == ADDR_CTRL && $urandom_range(0, 1) == 1) begin
      c.write_data[IRQ_BIT] = 1'b1;
      c.write_data[FIRQ_BIT] = 1'b1;
    end
    return c;
  endfunction

  task automatic wait_idle();
    do @(negedge clk);
    while (!(cmd_backlog.size() == 0 && !cmd_valid && due_rsp.size() == 0));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
      gap_left <= 0;
      burst_left <= 0;
    end else begin
      if (cmd_valid && !cmd_stall) due_rsp.push_back(advance_timer_regs(cmd));
      if (!cmd_valid || !cmd_stall) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          cmd_valid <= 1'b0;
        end else if (cmd_backlog.size() != 0) begin
          cmd <= cmd_backlog.pop_front();
          cmd_valid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 40);
            if ($urandom_range(0, 3) == 0) gap_left <= 0;
            else if ($urandom_range(0, 3) == 0) gap_left <= $urandom_range(4, 12);
            else gap_left <= $urandom_range(1, 3);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          cmd_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        check_rsp(rsp);
        rsp_taken++;
        if (rsp_taken == 300 || rsp_taken == 1000) hold_left = LONG_HOLD;
      end
      rx_cycle++;
      if (rx_cycle % 64 == 0) stall_mode = $urandom_range(0, 2);
      if (hold_left != 0) begin
        hold_left--;
        rsp_stall <= 1'b1;
      end else begin
        case (stall_mode)
          0: rsp_stall <= 1'b0;
          1: rsp_stall <= ($urandom_range(0, 3) == 0);
          default: rsp_stall <= ($urandom_range(0, 3) != 0);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    push_cmd(KIND_READ, ADDR_FREE, '0);
    push_cmd(KIND_READ, ADDR_MCNT, '0);
    push_cmd(KIND_READ, ADDR_MVAL, '0);
    push_cmd(KIND_READ, ADDR_CTRL, '0);
    push_cmd(KIND_READ, ADDR_STAT, '0);
    push_cmd(KIND_WRITE, ADDR_FREE, 32'hFFFF_FFFF);
    push_cmd(KIND_WRITE, ADDR_MCNT, 32'h1234_5678);
    push_cmd(KIND_WRITE, ADDR_UART, 32'hFFFF_FFA5);
    push_cmd(KIND_WRITE, ADDR_DEBUG, 32'hFFFF_FFFF);
    push_cmd(KIND_WRITE, ADDR_STOP, 32'hFFFF_FFFF);
    push_cmd(KIND_READ, ADDR_STOP, '0);
    push_cmd(KIND_READ, ADDR_UART, '0);
    push_cmd(KIND_READ, ADDR_DEBUG, '0);
    push_cmd(KIND_UNUSED, ADDR_CTRL, 32'hFFFF_FFFF);
    push_cmd(KIND_WRITE, 32'h0000_0000, 32'hFFFF_FFFF);
    push_cmd(KIND_READ, 32'hFFFF_FFFF, '0);
    push_cmd(KIND_WRITE, ADDR_MVAL, 32'd2);
    push_cmd(KIND_WRITE, ADDR_CTRL, 32'h0000_0C02);
    push_cmd(KIND_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_cmd(KIND_TICK, '0, '0);
    push_cmd(KIND_TICK, '0, '0);
    push_cmd(KIND_READ, ADDR_STAT, '0);
    push_cmd(KIND_WRITE, ADDR_STAT, 32'h0000_0400);
    push_cmd(KIND_WRITE, ADDR_STAT, 32'hFFFF_FFFF);
    push_cmd(KIND_WRITE, ADDR_MVAL, '0);
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    wait_idle();
    repeat (2) begin
      repeat (RANDOM_PER_PHASE) cmd_backlog.push_back(random_cmd());
      wait_idle();
    end
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/tirb_pkg.sv
hw/rtl/timer_irq_register_block.sv
hw/rtl/tirb_checker.sv
dv/tb_timer_irq_register_block.sv
